>>> hw/rtl/subarray_sum_divisible_counter_top_defines.svh
// Assertion macros shared by the RTL files.
`ifndef SUBARRAY_SUM_DIVISIBLE_COUNTER_TOP_DEFINES_SVH
`define SUBARRAY_SUM_DIVISIBLE_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssdc_pkg.sv
package ssdc_pkg;

    localparam int MAX_MODULUS = 1024;
    localparam int K_W         = $clog2(MAX_MODULUS) + 1;
    localparam int REM_W       = $clog2(MAX_MODULUS);
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = VAL_W + 2;
    localparam int MAG_W       = VAL_W + 1;
    localparam int STEP_W      = $clog2(MAG_W);
    localparam int EPOCH_W     = 8;
    localparam int ENTRY_W     = EPOCH_W + CNT_W;

    localparam logic [K_W-1:0]     K_MAX     = K_W'(MAX_MODULUS);
    localparam logic [K_W-1:0]     K_ONE     = K_W'(1);
    localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
    localparam logic [REM_W-1:0]   ADDR_LAST = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [K_W-1:0]   k;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [REM_W-1:0] rem;
    } t_mod_rsp;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [CNT_W-1:0]   tally;
    } t_entry;

endpackage

>>> hw/rtl/ssdc_in_if.sv
interface ssdc_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ssdc_pkg::VAL_W-1:0] value;
    logic                             last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

>>> hw/rtl/ssdc_out_if.sv
interface ssdc_out_if;
    logic                      valid;
    logic                      ready;
    logic [ssdc_pkg::CNT_W-1:0] pair_count;
    logic                      last_out;

    modport source (output valid, output pair_count, output last_out, input ready);
    modport sink   (input valid, input pair_count, input last_out, output ready);
endinterface

>>> hw/rtl/ssdc_ram.sv
module ssdc_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ssdc_mod.sv
`include "subarray_sum_divisible_counter_top_defines.svh"

// Bit-serial non-negative remainder of a signed magnitude by k.
module ssdc_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdc_pkg::t_mod_req i_req,
    output ssdc_pkg::t_mod_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [ssdc_pkg::STEP_W-1:0]  r_cnt;
    logic [ssdc_pkg::K_W-1:0]     r_part;
    logic [ssdc_pkg::MAG_W-1:0]   r_shift;
    logic                         r_neg;
    logic [ssdc_pkg::K_W-1:0]     r_k;

    logic [ssdc_pkg::K_W:0]       w_trial;
    logic [ssdc_pkg::K_W:0]       w_step;
    logic [ssdc_pkg::K_W-1:0]     w_fix;
    logic                         w_idle;

    always_comb begin
        w_trial = {r_part, r_shift[ssdc_pkg::MAG_W-1]};
        if (w_trial >= {1'b0, r_k}) begin
            w_step = w_trial - {1'b0, r_k};
        end else begin
            w_step = w_trial;
        end
    end

    always_comb begin
        if (r_neg && (r_part != '0)) begin
            w_fix = r_k - r_part;
        end else begin
            w_fix = r_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt   <= ssdc_pkg::STEP_W'(ssdc_pkg::MAG_W - 1);
            r_part  <= '0;
            r_shift <= i_req.mag;
            r_neg   <= i_req.neg;
            r_k     <= i_req.k;
        end else if (r_busy) begin
            r_cnt   <= r_cnt - 1'b1;
            r_part  <= w_step[ssdc_pkg::K_W-1:0];
            r_shift <= {r_shift[ssdc_pkg::MAG_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = w_fix[ssdc_pkg::REM_W-1:0];
    assign w_idle     = !r_busy && !r_done;

    `SSDC_ASSERT_SAME(a_start_free, i_clk, i_rst_n, i_req.start, w_idle, "start while busy")
    `SSDC_ASSERT_SAME(a_rem_below_k, i_clk, i_rst_n, r_done, w_fix < r_k, "remainder too big")
    `SSDC_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held high")

endmodule

>>> hw/rtl/subarray_sum_divisible_counter_top.sv
// Channel   Dir  Payload                          Handshake
// i_in      in   value[15:0] signed, last         valid/ready
// o_out     out  pair_count[31:0], last_out       valid/ready
// i_cfg_*   in   modulus[10:0]                    write enable
//
// Each item takes the accept cycle, 17 steps of the bit-serial remainder
// unit, one tally memory read and one read-modify-write; the next item waits.
// After reset, and after every 255th array, a clearing pass over all 1024 entries
// sweeps the tally memory; no item is accepted meanwhile.
// A result waits in the output register; the next item is accepted meanwhile,
// and the update stalls only if that register is still full.
`include "subarray_sum_divisible_counter_top_defines.svh"

module subarray_sum_divisible_counter_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [ssdc_pkg::K_W-1:0] i_cfg_wdata,
    ssdc_in_if.sink                 i_in,
    ssdc_out_if.source              o_out
);

    ssdc_pkg::t_state r_state;
    ssdc_pkg::t_state n_state;

    logic [ssdc_pkg::K_W-1:0]     r_modulus;
    logic [ssdc_pkg::K_W-1:0]     w_k;
    logic [ssdc_pkg::REM_W-1:0]   r_rem;
    logic [ssdc_pkg::CNT_W-1:0]   r_count;
    logic [ssdc_pkg::EPOCH_W-1:0] r_epoch;
    logic [ssdc_pkg::REM_W-1:0]   r_clr_addr;
    logic [ssdc_pkg::REM_W-1:0]   r_addr;
    logic                         r_last;
    logic                         r_out_valid;
    logic [ssdc_pkg::CNT_W-1:0]   r_out_count;
    logic                         r_out_last;

    ssdc_pkg::t_mod_req w_req;
    ssdc_pkg::t_mod_rsp w_rsp;
    ssdc_pkg::t_entry   w_rd;
    ssdc_pkg::t_entry   w_wr;

    logic [ssdc_pkg::SUM_W-1:0]   w_sum;
    logic [ssdc_pkg::SUM_W-1:0]   w_abs;
    logic [ssdc_pkg::CNT_W-1:0]   w_seen;
    logic [ssdc_pkg::CNT_W:0]     w_cnt_sum;
    logic [ssdc_pkg::CNT_W-1:0]   w_count_new;
    logic [ssdc_pkg::CNT_W-1:0]   w_tally_new;
    logic                         w_slot_free;
    logic                         w_load;
    logic                         w_accept;
    logic                         w_ram_we;
    logic [ssdc_pkg::REM_W-1:0]   w_ram_waddr;
    logic                         w_ram_re;
    logic                         w_wrap;
    logic                         w_clearing;
    logic                         w_clr_end;
    logic                         w_restart;
    logic                         w_in_div;
    logic                         w_in_look;

    // effective modulus: zero acts as one, large values clamp
    always_comb begin
        if (r_modulus == '0) begin
            w_k = ssdc_pkg::K_ONE;
        end else if (r_modulus > ssdc_pkg::K_MAX) begin
            w_k = ssdc_pkg::K_MAX;
        end else begin
            w_k = r_modulus;
        end
    end

    // (rem + value) mod k equals (rem + value mod k) mod k
    always_comb begin
        w_sum = {{(ssdc_pkg::SUM_W - ssdc_pkg::REM_W){1'b0}}, r_rem}
              + {{(ssdc_pkg::SUM_W - ssdc_pkg::VAL_W){i_in.value[ssdc_pkg::VAL_W-1]}},
                 i_in.value};
        if (w_sum[ssdc_pkg::SUM_W-1]) begin
            w_abs = ~w_sum + 1'b1;
        end else begin
            w_abs = w_sum;
        end
    end

    always_comb begin
        if (w_rd.tag == r_epoch) begin
            w_seen = w_rd.tally;
        end else if (r_addr == '0) begin
            w_seen = ssdc_pkg::CNT_W'(1);
        end else begin
            w_seen = '0;
        end
        w_cnt_sum = {1'b0, r_count} + {1'b0, w_seen};
        w_count_new = w_cnt_sum[ssdc_pkg::CNT_W] ? ssdc_pkg::COUNT_MAX
                                                 : w_cnt_sum[ssdc_pkg::CNT_W-1:0];
        w_tally_new = (w_seen == ssdc_pkg::COUNT_MAX) ? ssdc_pkg::COUNT_MAX
                                                      : w_seen + 1'b1;
    end

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_wrap      = (r_epoch == ssdc_pkg::EPOCH_MAX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ssdc_pkg::ST_CLEAR: begin
                if (r_clr_addr == ssdc_pkg::ADDR_LAST) begin
                    n_state = ssdc_pkg::ST_IDLE;
                end
            end
            ssdc_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ssdc_pkg::ST_DIV;
                end
            end
            ssdc_pkg::ST_DIV: begin
                if (w_rsp.done) begin
                    n_state = ssdc_pkg::ST_LOOK;
                end
            end
            ssdc_pkg::ST_LOOK: begin
                if (w_slot_free) begin
                    n_state = (r_last && w_wrap) ? ssdc_pkg::ST_CLEAR : ssdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssdc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        w_accept    = 1'b0;
        w_load      = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_addr;
        w_ram_re    = 1'b0;
        w_wr.tag    = r_epoch;
        w_wr.tally  = w_tally_new;
        case (r_state)
            ssdc_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_wr.tag    = '0;
                w_wr.tally  = '0;
            end
            ssdc_pkg::ST_IDLE: begin
                w_accept = i_in.valid;
            end
            ssdc_pkg::ST_DIV: begin
                w_ram_re = w_rsp.done;
            end
            ssdc_pkg::ST_LOOK: begin
                w_load   = w_slot_free;
                w_ram_we = w_slot_free;
            end
            default: begin
                w_accept = 1'b0;
            end
        endcase
    end

    assign i_in.ready = (r_state == ssdc_pkg::ST_IDLE);

    assign w_req.start = w_accept;
    assign w_req.neg   = w_sum[ssdc_pkg::SUM_W-1];
    assign w_req.mag   = w_abs[ssdc_pkg::MAG_W-1:0];
    assign w_req.k     = w_k;

    ssdc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    ssdc_ram #(
        .WIDTH (ssdc_pkg::ENTRY_W),
        .DEPTH (ssdc_pkg::MAX_MODULUS)
    ) u_tally (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_wr),
        .i_re    (w_ram_re),
        .i_raddr (w_rsp.rem),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssdc_pkg::ST_CLEAR;
            r_modulus   <= ssdc_pkg::K_ONE;
            r_rem       <= '0;
            r_count     <= '0;
            r_epoch     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (r_state == ssdc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ssdc_pkg::ADDR_LAST) begin
                    r_epoch <= ssdc_pkg::EPOCH_ONE;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_rem   <= '0;
                    r_count <= '0;
                    if (!w_wrap) begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end else begin
                    r_rem   <= r_addr;
                    r_count <= w_count_new;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_in.last;
        end
        if (w_ram_re) begin
            r_addr <= w_rsp.rem;
        end
        if (w_load) begin
            r_out_count <= w_count_new;
            r_out_last  <= r_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pair_count = r_out_count;
    assign o_out.last_out   = r_out_last;

    assign w_clearing = (r_state == ssdc_pkg::ST_CLEAR);
    assign w_clr_end  = w_clearing && (r_clr_addr == ssdc_pkg::ADDR_LAST);
    assign w_restart  = (r_epoch == ssdc_pkg::EPOCH_ONE) && (r_state == ssdc_pkg::ST_IDLE);
    assign w_in_div   = (r_state == ssdc_pkg::ST_DIV);
    assign w_in_look  = (r_state == ssdc_pkg::ST_LOOK);

    `SSDC_ASSERT_SAME(a_epoch_live, i_clk, i_rst_n, !w_clearing, r_epoch != '0, "stale epoch")
    `SSDC_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n, w_clr_end, w_restart, "epochs not restarted")
    `SSDC_ASSERT_NEXT(a_look_after_read, i_clk, i_rst_n, w_ram_re, w_in_look, "read without update")
    `SSDC_ASSERT_SAME(a_no_write_in_div, i_clk, i_rst_n, w_in_div, !w_ram_we, "write in remainder")

endmodule

>>> test/ssdc_count_checker.sv
`timescale 1ns / 1ps
module ssdc_count_checker
    import ssdc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [K_W-1:0] i_cfg_wdata,
    ssdc_in_if             i_in,
    ssdc_out_if            i_res,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);

    typedef struct packed {
        logic [CNT_W-1:0] pair_count;
        logic             last_out;
    } t_count;

    logic [K_W-1:0]   modulus_q;
    int               prefix_rem;
    logic [CNT_W-1:0] array_count;
    logic [CNT_W-1:0] rem_tally [MAX_MODULUS];
    logic             rem_seen  [MAX_MODULUS];
    t_count           expected_counts [$];
    int               fails;
    int               checked;

    function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic void clear_array();
        for (int i = 0; i < MAX_MODULUS; i++) rem_seen[i] = 1'b0;
        prefix_rem  = 0;
        array_count = '0;
    endfunction

    function automatic t_count count_element(input logic signed [VAL_W-1:0] value,
                                             input logic last);
        int               k;
        int               m;
        logic [CNT_W-1:0] seen;
        t_count           res;
        k = (modulus_q == '0) ? 1 : (modulus_q > K_MAX) ? MAX_MODULUS : int'(modulus_q);
        m = int'(value) % k;
        if (m < 0) m += k;
        prefix_rem = (prefix_rem + m) % k;
        if (rem_seen[prefix_rem]) begin
            seen = rem_tally[prefix_rem];
        end else begin
            seen = (prefix_rem == 0) ? CNT_W'(1) : '0;
        end
        array_count           = add_clamped(array_count, seen);
        rem_tally[prefix_rem] = add_clamped(seen, CNT_W'(1));
        rem_seen[prefix_rem]  = 1'b1;
        res.pair_count = array_count;
        res.last_out   = last;
        if (last) clear_array();
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_count want;
        if (!i_rst_n) begin
            modulus_q = K_ONE;
            clear_array();
            expected_counts.delete();
            fails   = 0;
            checked = 0;
        end else begin
            if (i_cfg_we) modulus_q = i_cfg_wdata;
            if (i_res.valid && i_res.ready) begin
                if (expected_counts.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result: count %0d last %0b",
                                 i_res.pair_count, i_res.last_out);
                    fails++;
                end else begin
                    want = expected_counts.pop_front();
                    checked++;
                    if (i_res.pair_count !== want.pair_count ||
                        i_res.last_out !== want.last_out) begin
                        if (fails < 10)
                            $display("mismatch on result %0d: expected count %0d last %0b, got count %0d last %0b",
                                     checked, want.pair_count, want.last_out,
                                     i_res.pair_count, i_res.last_out);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_counts.push_back(count_element(i_in.value, i_in.last));
        end
        o_fail_count <= fails;
        o_pending    <= expected_counts.size();
        o_checked    <= checked;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
    import ssdc_pkg::*;

    localparam int ITEM_TARGET = 1250;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_we = 1'b0;
    logic [K_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int arrays_sent = 0;
    int settings = 0;
    int eff_k = 1;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    ssdc_in_if  in_ch ();
    ssdc_out_if out_ch ();

    subarray_sum_divisible_counter_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    ssdc_count_checker count_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .i_res       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #6 clk = ~clk;

    initial begin
        #6_000_000;
        $display("subarray_sum_divisible_counter_top regression: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic signed [VAL_W-1:0] value, input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.last  <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
        if (last) arrays_sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [K_W-1:0] k);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_k = (k == '0) ? 1 : (k > K_MAX) ? MAX_MODULUS : int'(k);
        settings++;
    endtask

    initial begin
        int             phase;
        int             phase_len;
        int             arr_left;
        int             v;
        logic [K_W-1:0] k;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.last  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset modulus of one, field extremes
        send_item(0, 1'b0);
        send_item(32767, 1'b0);
        send_item(-32768, 1'b1);
        settle();
        // zero modulus acts as one
        write_modulus(0);
        send_item(-1, 1'b0);
        send_item(5, 1'b1);
        settle();
        // negative elements need a non-negative remainder
        write_modulus(7);
        send_item(7, 1'b0);
        send_item(-7, 1'b0);
        send_item(3, 1'b0);
        send_item(-3, 1'b0);
        send_item(-32768, 1'b0);
        send_item(32767, 1'b0);
        send_item(0, 1'b1);
        settle();
        // oversized modulus clamps to the maximum, then changes mid-array
        write_modulus(2047);
        send_item(1024, 1'b0);
        send_item(-1024, 1'b0);
        send_item(1, 1'b0);
        send_item(1023, 1'b0);
        settle();
        write_modulus(3);
        send_item(2, 1'b0);
        send_item(1, 1'b0);
        send_item(-32768, 1'b1);
        settle();
        write_modulus(1024);
        send_item(512, 1'b0);
        send_item(512, 1'b0);
        send_item(-1, 1'b1);
        settle();

        phase    = 0;
        arr_left = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       k = '0;
                1:       k = K_MAX;
                2:       k = '1;
                3:       k = K_W'($urandom_range(MAX_MODULUS + 1, 2047));
                4, 5:    k = K_W'($urandom_range(2, 8));
                6, 7:    k = K_W'($urandom_range(9, 64));
                8:       k = K_W'($urandom_range(65, MAX_MODULUS - 1));
                default: k = K_ONE;
            endcase
            write_modulus(k);
            // one long run of single-element arrays drives the epoch rollover
            phase_len = (phase == 1) ? 300 : $urandom_range(40, 150);
            if (phase == 3) hold_req = 1'b1;
            for (int n = 0; n < phase_len; n++) begin
                quiet = (items_sent >= ITEM_TARGET - 150);
                if (arr_left == 0) begin
                    if (phase == 1)
                        arr_left = 1;
                    else if ($urandom_range(0, 19) < 13)
                        arr_left = $urandom_range(1, 2);
                    else if ($urandom_range(0, 1) == 0)
                        arr_left = $urandom_range(3, 8);
                    else
                        arr_left = $urandom_range(9, 40);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: v = $urandom;
                    3, 4, 5: v = int'($urandom_range(0, 40)) - 20;
                    6, 7:    v = eff_k * (int'($urandom_range(0, 20)) - 10);
                    8:       v = eff_k * (int'($urandom_range(0, 20)) - 10)
                                 + (($urandom_range(0, 1) == 0) ? 1 : -1);
                    default: v = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
                endcase
                arr_left--;
                send_item(v[VAL_W-1:0], arr_left == 0);
            end
            settle();
            phase++;
        end

        repeat (40) @(posedge clk);
        $display("run covered %0d items in %0d arrays across %0d modulus writes",
                 items_sent, arrays_sent, settings);
        $display("%0d counts checked, including a long output stall and mid-array changes",
                 checked);
        if (fail_count == 0) begin
            $display("subarray_sum_divisible_counter_top regression: pass");
        end else begin
            $display("subarray_sum_divisible_counter_top regression: fail");
        end
        $finish;
    end

endmodule
